// ===== rtl/core/websocket_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer's modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wsfd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
// Depends on nothing; imported by every module of the block.
package wsfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;

    localparam logic [OPCODE_W-1:0] OP_CLOSE      = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING       = 4'h9;
    localparam logic [6:0]          LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0]          LEN_EXT16     = 7'd126;
    localparam logic [6:0]          LEN_EXT64     = 7'd127;

    // Extended length byte counts, stored minus one
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [1:0] KEY_LAST   = 2'd3;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ACT_DELIVER = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_PING    = 2'd2
    } action_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                has_byte;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                final_flag;
        logic                frame_end;
        action_t             action;
    } result_t;

endpackage

// ===== rtl/core/wsfd_parser.sv =====
// Input register and frame parsing state of the deframer.
// Depends on wsfd_pkg and websocket_frame_deframer_assert.svh.
`include "websocket_frame_deframer_assert.svh"

module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              out_full,
    output logic              res_push,
    output result_t           res
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    phase_t              phase_reg, phase_next;
    logic [2:0]          byte_count_reg, byte_count_next;
    logic                fin_bit_reg, fin_bit_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                mask_bit_reg, mask_bit_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [KEY_W-1:0]    mask_key_reg, mask_key_next;
    logic [1:0]          key_index_reg, key_index_next;
    logic                closed_reg, closed_next;

    logic              fire;
    logic              res_valid;
    logic [6:0]        len7;
    logic [LEN_W-1:0]  len_shift;
    logic [BYTE_W-1:0] key_byte;
    action_t           act;

    function automatic action_t frame_action(input logic fin, input logic [OPCODE_W-1:0] op);
        action_t a;
        a = ACT_DELIVER;
        if (fin && op == OP_CLOSE)
        begin
            a = ACT_CLOSE;
        end
        else if (fin && op == OP_PING)
        begin
            a = ACT_PING;
        end
        return a;
    endfunction

    // Work the held item whenever the output side has a free slot
    assign fire     = in_valid_reg && !out_full;
    assign in_ready = !in_valid_reg || !out_full;

    assign len7      = in_byte_reg[6:0];
    assign len_shift = {remaining_reg[LEN_W-BYTE_W-1:0], in_byte_reg};
    assign act       = frame_action(fin_bit_reg, opcode_reg);

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        fin_bit_next    = fin_bit_reg;
        opcode_next     = opcode_reg;
        mask_bit_next   = mask_bit_reg;
        remaining_next  = remaining_reg;
        mask_key_next   = mask_key_reg;
        key_index_next  = key_index_reg;
        closed_next     = closed_reg;
        res_valid       = 1'b0;
        res.payload_byte = '0;
        res.has_byte     = 1'b0;
        res.frame_opcode = opcode_reg;
        res.final_flag   = fin_bit_reg;
        res.frame_end    = 1'b0;
        res.action       = ACT_DELIVER;

        if (fire)
        begin
            in_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end

        if (fire && !closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_bit_next = in_byte_reg[7];
                    if (len7 <= LEN_MAX_SHORT)
                    begin
                        remaining_next = {{(LEN_W-7){1'b0}}, len7};
                        key_index_next = '0;
                        if (in_byte_reg[7])
                        begin
                            phase_next = PH_KEY;
                        end
                        else if (len7 != '0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        remaining_next  = '0;
                        byte_count_next = (len7 == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
                        phase_next      = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    remaining_next = len_shift;
                    if (byte_count_reg != '0)
                    begin
                        byte_count_next = byte_count_reg - 3'd1;
                    end
                    else
                    begin
                        key_index_next = '0;
                        if (mask_bit_reg)
                        begin
                            phase_next = PH_KEY;
                        end
                        else if (len_shift != '0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    mask_key_next = {mask_key_reg[KEY_W-BYTE_W-1:0], in_byte_reg};
                    if (key_index_reg != KEY_LAST)
                    begin
                        key_index_next = key_index_reg + 2'd1;
                    end
                    else
                    begin
                        key_index_next = '0;
                        if (remaining_reg != '0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                        end
                    end
                end
                PH_DATA:
                begin
                    res_valid        = 1'b1;
                    res.has_byte     = 1'b1;
                    res.payload_byte = mask_bit_reg ? (in_byte_reg ^ key_byte) : in_byte_reg;
                    key_index_next   = key_index_reg + 2'd1;
                    remaining_next   = remaining_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                end
                default:
                begin
                    fin_bit_next = in_byte_reg[7];
                    opcode_next  = in_byte_reg[OPCODE_W-1:0];
                    phase_next   = PH_HDR1;
                end
            endcase

            // Close out the frame: empty-frame marker or last payload byte
            if (res_valid && (!res.has_byte || remaining_reg == {{(LEN_W-1){1'b0}}, 1'b1}))
            begin
                res.frame_end   = 1'b1;
                res.action      = act;
                phase_next      = PH_HDR0;
                byte_count_next = '0;
                key_index_next  = '0;
                if (act == ACT_CLOSE)
                begin
                    closed_next = 1'b1;
                end
            end
        end
    end

    assign res_push = res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_HDR0;
            byte_count_reg <= '0;
            fin_bit_reg    <= 1'b0;
            opcode_reg     <= '0;
            mask_bit_reg   <= 1'b0;
            remaining_reg  <= '0;
            mask_key_reg   <= '0;
            key_index_reg  <= '0;
            closed_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            fin_bit_reg    <= fin_bit_next;
            opcode_reg     <= opcode_next;
            mask_bit_reg   <= mask_bit_next;
            remaining_reg  <= remaining_next;
            mask_key_reg   <= mask_key_next;
            key_index_reg  <= key_index_next;
            closed_reg     <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    `WSFD_ASSERT_NEXT(a_closed_sticky, clk, rst_n, closed_reg, closed_reg,
        "closed state was left without reset")
    `WSFD_ASSERT_NEXT(a_close_latches, clk, rst_n,
        res_push && res.frame_end && res.action == ACT_CLOSE, closed_reg,
        "close frame did not latch the closed state")
    `WSFD_ASSERT_NOW(a_data_len, clk, rst_n, phase_reg == PH_DATA, remaining_reg != '0,
        "payload phase with no bytes left")

endmodule

// ===== rtl/core/wsfd_out_skid.sv =====
// Two-entry output stage (result register plus skid register) of the deframer.
// Depends on wsfd_pkg and websocket_frame_deframer_assert.svh.
`include "websocket_frame_deframer_assert.svh"

module wsfd_out_skid
    import wsfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;
    logic    drain;

    assign drain = !out_valid_reg || out_ready;
    assign full  = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `WSFD_ASSERT_NOW(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while result register empty")
    `WSFD_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !skid_valid_reg,
        "result pushed into a full output stage")
    `WSFD_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, push && out_valid_reg && !out_ready,
        skid_valid_reg, "stalled result was not parked in the skid entry")

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser plus output stage.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_skid.
//
//  channel | dir | tdata                                | tuser                 | tlast
//  --------+-----+--------------------------------------+-----------------------+----------
//  s_*     | in  | [7:0] data_byte                      | -                     | -
//  m_*     | out | [7:0] payload_byte, [11:8] opcode,   | [0] has_byte,         | frame_end
//          |     | [12] final_flag, [15:13] zero        | [2:1] action          |
//
// Flow: one item per cycle while the output stage is not full; each received byte is
// registered, then parsed against the frame state registers, and its result is
// registered in the output stage before it appears on m_*.
// Reset: rst_n clears the parser to the first header byte and empties the output.
// Stalls: a two-entry output stage absorbs an m_tready drop; s_tready falls
// only once both output entries and the input register are occupied.
// After a close frame every further item is taken and dropped until reset.
module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [12] final_flag
    output logic [2:0]  m_tuser,   // [0] has_byte, [2:1] action
    output logic        m_tlast    // frame_end
);

    result_t res;
    result_t out_res;
    logic    res_push;
    logic    out_full;

    // Parse one byte per cycle; hold the input item while the output is full
    wsfd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .out_full (out_full),
        .res_push (res_push),
        .res      (res)
    );

    // Decouple the downstream ready from the input side
    wsfd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_res  (res),
        .full      (out_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.final_flag, out_res.frame_opcode, out_res.payload_byte};
    assign m_tuser = {out_res.action, out_res.has_byte};
    assign m_tlast = out_res.frame_end;

endmodule

// ===== bench/frame_stream_checker.sv =====
// Scoreboard for the WebSocket frame deframer: predicts every output item from the
// accepted input bytes and compares field by field. Depends on wsfd_pkg.
`timescale 1ns / 1ps

module frame_stream_checker
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [12] final_flag
    input  logic [2:0]  m_tuser,   // [0] has_byte, [2:1] action
    input  logic        m_tlast,   // frame_end
    output int          mismatch_count,
    output int          pending_results
);

    // Frame parser state
    phase_t      ph;
    logic        fin_q;
    logic [3:0]  op_q;
    logic        mask_q;
    logic [63:0] len_left;
    logic [31:0] key_q;
    logic [1:0]  key_pos;
    logic [2:0]  ext_left;
    logic        closed_q;

    result_t expected_outputs[$];

    initial mismatch_count = 0;

    task automatic reset_parser();
        ph       = PH_HDR0;
        fin_q    = 1'b0;
        op_q     = '0;
        mask_q   = 1'b0;
        len_left = '0;
        key_q    = '0;
        key_pos  = '0;
        ext_left = '0;
        closed_q = 1'b0;
    endtask

    task automatic push_expected(input logic [7:0] pb, input logic has, input logic last,
                                 input action_t act);
        result_t r;
        r.payload_byte = pb;
        r.has_byte     = has;
        r.frame_opcode = op_q;
        r.final_flag   = fin_q;
        r.frame_end    = last;
        r.action       = act;
        expected_outputs.push_back(r);
    endtask

    // Pick the frame's action, latch closed on a final close frame, go back to header
    task automatic end_frame(output action_t act);
        act = ACT_DELIVER;
        if (fin_q && op_q == OP_CLOSE)
        begin
            act      = ACT_CLOSE;
            closed_q = 1'b1;
        end
        else if (fin_q && op_q == OP_PING)
        begin
            act = ACT_PING;
        end
        ph       = PH_HDR0;
        ext_left = '0;
        key_pos  = '0;
    endtask

    // Enter the payload, or close out an empty frame with a marker item
    task automatic start_payload();
        action_t act;
        key_pos = '0;
        if (len_left != 0)
        begin
            ph = PH_DATA;
        end
        else
        begin
            end_frame(act);
            push_expected(8'h00, 1'b0, 1'b1, act);
        end
    endtask

    task automatic length_known();
        key_pos = '0;
        if (mask_q)
        begin
            key_q = '0;
            ph    = PH_KEY;
        end
        else
        begin
            start_payload();
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] pb;
        action_t    act;
        if (closed_q)
            return;
        case (ph)
            PH_HDR1:
            begin
                mask_q   = b[7];
                len_left = '0;
                if (b[6:0] <= LEN_MAX_SHORT)
                begin
                    len_left = {57'd0, b[6:0]};
                    length_known();
                end
                else
                begin
                    ext_left = (b[6:0] == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
                    ph       = PH_EXT;
                end
            end
            PH_EXT:
            begin
                len_left = {len_left[55:0], b};
                if (ext_left != 0)
                    ext_left = ext_left - 3'd1;
                else
                    length_known();
            end
            PH_KEY:
            begin
                key_q = {key_q[23:0], b};
                if (key_pos != KEY_LAST)
                    key_pos = key_pos + 2'd1;
                else
                    start_payload();
            end
            PH_DATA:
            begin
                // First key byte received sits in the top of key_q
                pb       = mask_q ? (b ^ key_q[8 * (3 - int'(key_pos)) +: 8]) : b;
                key_pos  = key_pos + 2'd1;
                len_left = len_left - 64'd1;
                if (len_left == 0)
                begin
                    end_frame(act);
                    push_expected(pb, 1'b1, 1'b1, act);
                end
                else
                begin
                    push_expected(pb, 1'b1, 1'b0, ACT_DELIVER);
                end
            end
            default:
            begin
                fin_q = b[7];
                op_q  = b[3:0];
                ph    = PH_HDR1;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_output();
        result_t want;
        if (expected_outputs.size() == 0)
        begin
            report_mismatch("output item with none expected", m_tdata[7:0], 8'h00);
            return;
        end
        want = expected_outputs.pop_front();
        if (m_tdata[7:0] !== want.payload_byte)
            report_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
        if (m_tuser[0] !== want.has_byte)
            report_mismatch("has_byte", 8'(m_tuser[0]), 8'(want.has_byte));
        if (m_tdata[11:8] !== want.frame_opcode)
            report_mismatch("frame_opcode", 8'(m_tdata[11:8]), 8'(want.frame_opcode));
        if (m_tdata[12] !== want.final_flag)
            report_mismatch("final_flag", 8'(m_tdata[12]), 8'(want.final_flag));
        if (m_tlast !== want.frame_end)
            report_mismatch("frame_end", 8'(m_tlast), 8'(want.frame_end));
        if (m_tuser[2:1] !== want.action)
            report_mismatch("action", 8'(m_tuser[2:1]), 8'(want.action));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            expected_outputs.delete();
            pending_results <= 0;
        end
        else
        begin
            // A byte's result is never visible in the cycle it is taken
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_output();
            pending_results <= expected_outputs.size();
        end
    end

endmodule

// ===== bench/tb_websocket_frame_deframer.sv =====
// Testbench top for the WebSocket frame deframer: builds frame byte streams and
// drives them with random idling. Depends on wsfd_pkg, the block and frame_stream_checker.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_BYTES  = 300;
    localparam int DRAIN_CYCLES = 20;

    // Opcodes used by name in the directed frames
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    // How the payload length is carried in the header
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [7:0] payload_byte, [11:8] frame_opcode, [12] final_flag
    logic [2:0]  m_tuser;              // [0] has_byte, [2:1] action
    logic        m_tlast;              // frame_end

    int mismatch_count;
    int pending_results;

    // Bytes waiting to be offered on the input channel
    logic [7:0] rx_stream[$];
    int         bytes_queued    = 0;
    int         sender_idle_pct = 0;
    int         recv_stall_pct  = 0;
    bit         hold_off        = 1'b0;
    bit         pressure_go     = 1'b0;
    int         cycles          = 0;

    websocket_frame_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frame_stream_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sender: load the next byte once the current item is taken, or idle at random
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_stream.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold off entirely during the pressure window
    always @(posedge clk)
    begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Pressure: hold the output off long enough to fill the block and stall its input
    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // Watchdog: give up when the run takes far longer than any correct run could
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endtask

    // Append one complete frame; payload bytes are random
    task automatic push_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input logic [31:0] key,
                              input len_form_t form, input logic [63:0] len);
        logic [6:0] len7;
        push_byte({fin, rsv, op});
        case (form)
            FORM_EXT16: len7 = wsfd_pkg::LEN_EXT16;
            FORM_EXT64: len7 = wsfd_pkg::LEN_EXT64;
            default:    len7 = len[6:0];
        endcase
        push_byte({masked, len7});
        if (form == FORM_EXT16)
        begin
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end
        else if (form == FORM_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                push_byte(len[8 * i +: 8]);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                push_byte(key[8 * i +: 8]);
        end
        for (longint unsigned i = 0; i < len; i++)
            push_byte(8'($urandom_range(255)));
    endtask

    // Random frame: any opcode and header bits, mostly short payloads.
    // A final close frame is kept for the end, since it shuts the block for good.
    // A length with the top bit set never completes, so extended lengths stay short.
    task automatic random_frame();
        logic        fin;
        logic [3:0]  op;
        int          pick;
        len_form_t   form;
        logic [63:0] len;
        fin  = 1'($urandom_range(1));
        op   = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (fin && op == wsfd_pkg::OP_CLOSE)
            fin = 1'b0;
        if (pick < 55)
        begin
            form = FORM_SHORT;
            len  = 64'($urandom_range(12));
        end
        else if (pick < 60)
        begin
            form = FORM_SHORT;
            len  = 64'(wsfd_pkg::LEN_MAX_SHORT);
        end
        else if (pick < 72)
        begin
            form = FORM_EXT16;
            len  = 64'($urandom_range(30));
        end
        else if (pick < 78)
        begin
            form = FORM_EXT16;
            len  = 64'($urandom_range(260, 126));
        end
        else if (pick < 92)
        begin
            form = FORM_EXT64;
            len  = 64'($urandom_range(30));
        end
        else
        begin
            form = FORM_SHORT;
            len  = 64'($urandom_range(125, 13));
        end
        push_frame(fin, 3'($urandom_range(7)), op, 1'($urandom_range(1)), $urandom,
                   form, len);
    endtask

    // Wait until every queued byte has been taken by the block
    task automatic wait_sent();
        while (rx_stream.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input bit with_pressure);
        int target;
        @(negedge clk);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        pressure_go     = with_pressure;
        target          = bytes_queued + PHASE_BYTES;
        while (bytes_queued < target)
            random_frame();
        wait_sent();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames, no idling
        // Empty unmasked frame: marker item on the second header byte
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 32'h0, FORM_SHORT, 64'd0);
        // Masked continuation with all reserved bits set
        push_frame(1'b0, 3'b111, OP_CONT, 1'b1, 32'hFF00_A55A, FORM_SHORT, 64'd3);
        // Empty masked ping: marker on the last key byte, carrying the ping action
        push_frame(1'b1, 3'b000, wsfd_pkg::OP_PING, 1'b1, 32'h00FF_00FF, FORM_SHORT, 64'd0);
        // Empty frame with a 16-bit length and a reserved opcode
        push_frame(1'b0, 3'b010, OP_RSVD_F, 1'b0, 32'h0, FORM_EXT16, 64'd0);
        // Close opcode without fin is delivered and does not close
        push_frame(1'b0, 3'b000, wsfd_pkg::OP_CLOSE, 1'b0, 32'h0, FORM_SHORT, 64'd1);
        wait_sent();

        // Random traffic through the idling phases
        run_random_phase(0, 0, 1'b1);
        run_random_phase(45, 0, 1'b0);
        run_random_phase(0, 45, 1'b0);
        run_random_phase(22, 22, 1'b0);

        // Final close frame, then bytes the closed block must drop
        @(negedge clk);
        push_frame(1'b1, 3'b000, wsfd_pkg::OP_CLOSE, 1'b1, $urandom, FORM_SHORT, 64'd2);
        for (int i = 0; i < 12; i++)
            push_byte(8'($urandom_range(255)));
        wait_sent();

        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
